@@ rtl/trqd_pkg.sv @@
// ----------------------------------------------------------------------------
// trqd_pkg
// Shared types and default sizes for the task run queue deque.
// ----------------------------------------------------------------------------
package trqd_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int PID_BITS_DEF   = 16;
  localparam int STATE_BITS_DEF = 4;

  localparam int KIND_W   = 3;
  localparam int STATUS_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND  = 3'd0,
    KIND_PREPEND = 3'd1,
    KIND_POP     = 3'd2,
    KIND_FIND    = 3'd3,
    KIND_CLEAR   = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_FULL    = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_MISSING = 3'd4
  } status_t;

  // What a slot cell does at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_LOAD_NEW  = 2'd1,
    CELL_FROM_PREV = 2'd2,
    CELL_FROM_NEXT = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     live;
  } cell_ctrl_t;

endpackage

@@ rtl/task_run_queue_deque_unit.sv @@
// The result beat is registered and valid in the cycle after its input beat is accepted.
// Throughput: one operation per cycle while results are taken; each slot
// cell compares and shifts in parallel.
// Reset clears the task count and the result valid; slot contents are not
// cleared and need no clearing pass, since only live slots are ever read.
// ----------------------------------------------------------------------------
// task_run_queue_deque_unit
// Bounded double-ended run queue of tasks held in a row of shifting slot
// cells, with duplicate pid check, pop at head, find by pid and clear.
// ----------------------------------------------------------------------------
module task_run_queue_deque_unit #(
  parameter int CAPACITY   = trqd_pkg::CAPACITY_DEF,
  parameter int PID_BITS   = trqd_pkg::PID_BITS_DEF,
  parameter int STATE_BITS = trqd_pkg::STATE_BITS_DEF,
  localparam int CNT_W     = $clog2(CAPACITY + 1),
  localparam int IN_W      = ((PID_BITS + STATE_BITS + 7) / 8) * 8,
  localparam int OUT_W     = ((PID_BITS + STATE_BITS + CNT_W + 1 + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [IN_W-1:0]               in_tdata,   // task_pid, task_state
  input  logic [trqd_pkg::KIND_W-1:0]   in_tuser,   // kind
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [OUT_W-1:0]              out_tdata,  // out_pid, out_state, count, is_empty
  output logic [trqd_pkg::STATUS_W-1:0] out_tuser   // status
);
  import trqd_pkg::*;

  logic                  accept;
  kind_t                 kind;
  logic [PID_BITS-1:0]   key_pid;
  logic [STATE_BITS-1:0] key_state;

  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]      out_data_r;
  logic [STATUS_W-1:0]   out_status_r;

  cell_ctrl_t            ctrl      [CAPACITY];
  logic [PID_BITS-1:0]   cell_pid  [CAPACITY];
  logic [STATE_BITS-1:0] cell_state[CAPACITY];
  logic [CAPACITY-1:0]   match;

  logic                  hit, full, empty;
  logic [PID_BITS-1:0]   hit_pid;
  logic [STATE_BITS-1:0] hit_state;
  status_t               status_nxt;
  logic [PID_BITS-1:0]   res_pid;
  logic [STATE_BITS-1:0] res_state;
  cell_op_t              row_op;
  logic                  load_tail;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign kind      = kind_t'(in_tuser);
  assign key_pid   = in_tdata[PID_BITS-1:0];
  assign key_state = in_tdata[PID_BITS +: STATE_BITS];

  // Slot row: cell 0 is the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [PID_BITS-1:0]   p_pid, n_pid;
    logic [STATE_BITS-1:0] p_state, n_state;
    if (i == 0) begin : g_first
      assign p_pid   = key_pid;
      assign p_state = key_state;
    end else begin : g_mid
      assign p_pid   = cell_pid[i-1];
      assign p_state = cell_state[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign n_pid   = cell_pid[i];
      assign n_state = cell_state[i];
    end else begin : g_inner
      assign n_pid   = cell_pid[i+1];
      assign n_state = cell_state[i+1];
    end

    trqd_cell #(
      .PID_BITS   (PID_BITS),
      .STATE_BITS (STATE_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl[i]),
      .key_pid    (key_pid),
      .new_pid    (key_pid),
      .new_state  (key_state),
      .prev_pid   (p_pid),
      .prev_state (p_state),
      .next_pid   (n_pid),
      .next_state (n_state),
      .pid        (cell_pid[i]),
      .state      (cell_state[i]),
      .match      (match[i])
    );
  end

  // Pids in the row are unique, so at most one cell matches: OR the hit out
  always_comb begin
    hit_pid   = '0;
    hit_state = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i]) begin
        hit_pid   = hit_pid | cell_pid[i];
        hit_state = hit_state | cell_state[i];
      end
    end
  end

  assign hit   = |match;
  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);

  // Operation decode
  always_comb begin
    status_nxt = ST_OK;
    res_pid    = '0;
    res_state  = '0;
    count_nxt  = count_r;
    row_op     = CELL_HOLD;
    load_tail  = 1'b0;
    case (kind)
      KIND_APPEND, KIND_PREPEND: begin
        if (hit) begin
          status_nxt = ST_DUP;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
          if (kind == KIND_APPEND) begin
            load_tail = 1'b1;
          end else begin
            row_op = CELL_FROM_PREV;
          end
        end
      end
      KIND_POP: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          res_pid   = cell_pid[0];
          res_state = cell_state[0];
          count_nxt = count_r - 1'b1;
          row_op    = CELL_FROM_NEXT;
        end
      end
      KIND_FIND: begin
        if (hit) begin
          res_pid   = hit_pid;
          res_state = hit_state;
        end else begin
          status_nxt = ST_MISSING;
        end
      end
      KIND_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  // Per-cell control
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctrl[i].live = (CNT_W'(i) < count_r);
      ctrl[i].op   = CELL_HOLD;
      if (accept) begin
        if (load_tail) begin
          ctrl[i].op = (CNT_W'(i) == count_r) ? CELL_LOAD_NEW : CELL_HOLD;
        end else if (row_op == CELL_FROM_PREV) begin
          ctrl[i].op = (i == 0) ? CELL_LOAD_NEW : CELL_FROM_PREV;
        end else if (row_op == CELL_FROM_NEXT) begin
          ctrl[i].op = (i == CAPACITY - 1) ? CELL_HOLD : CELL_FROM_NEXT;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // Result payload: hold until the beat is taken
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status_nxt;
      out_data_r   <= OUT_W'({(count_nxt == '0), count_nxt, res_state, res_pid});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("task count above capacity");

  a_unique_pid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(match) <= 1)
    else $error("pid held in more than one live slot");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (kind == KIND_CLEAR) |=> (count_r == '0))
    else $error("clear left tasks queued");

  a_dup_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (status_nxt == ST_DUP) |=> $stable(count_r))
    else $error("rejected insert changed the count");
`endif

endmodule

@@ rtl/trqd_cell.sv @@
// ----------------------------------------------------------------------------
// trqd_cell
// One queue slot: holds a pid and state, compares its pid against the key
// and loads from the new task or from either neighbour.
// ----------------------------------------------------------------------------
module trqd_cell #(
  parameter int PID_BITS   = 16,
  parameter int STATE_BITS = 4
) (
  input  logic                  clk,
  input  trqd_pkg::cell_ctrl_t  ctrl,
  input  logic [PID_BITS-1:0]   key_pid,
  input  logic [PID_BITS-1:0]   new_pid,
  input  logic [STATE_BITS-1:0] new_state,
  input  logic [PID_BITS-1:0]   prev_pid,
  input  logic [STATE_BITS-1:0] prev_state,
  input  logic [PID_BITS-1:0]   next_pid,
  input  logic [STATE_BITS-1:0] next_state,
  output logic [PID_BITS-1:0]   pid,
  output logic [STATE_BITS-1:0] state,
  output logic                  match
);
  import trqd_pkg::*;

  logic [PID_BITS-1:0]   pid_r;
  logic [STATE_BITS-1:0] state_r;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_LOAD_NEW: begin
        pid_r   <= new_pid;
        state_r <= new_state;
      end
      CELL_FROM_PREV: begin
        pid_r   <= prev_pid;
        state_r <= prev_state;
      end
      CELL_FROM_NEXT: begin
        pid_r   <= next_pid;
        state_r <= next_state;
      end
      default: begin
        pid_r   <= pid_r;
        state_r <= state_r;
      end
    endcase
  end

  assign pid   = pid_r;
  assign state = state_r;
  assign match = ctrl.live && (pid_r == key_pid);

endmodule

@@ tb/sv/task_run_queue_deque_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// task_run_queue_deque_unit_tb
// Self-checking bench for the task run queue. Every accepted input beat is
// applied to a queue model kept here, and each result beat is compared
// field by field against the oldest prediction. A short directed part covers
// the empty, duplicate and full cases. Random traffic follows, with sender
// gaps and receiver stalls varied from phase to phase.
// ----------------------------------------------------------------------------
module task_run_queue_deque_unit_tb;
  import trqd_pkg::*;

  localparam int QUEUE_DEPTH = CAPACITY_DEF;
  localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [15:0] pid;
    logic [3:0]  state;
  } task_entry_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] pid;
    logic [3:0]  state;
    logic [4:0]  count;
    logic        is_empty;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;

  task_entry_t run_q[$];
  result_t     pending_results[$];
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          mismatch_count = 0;
  int          results_checked = 0;
  int          status_hits[5] = '{default: 0};
  int          full_hits = 0;

  task_run_queue_deque_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= stall_pct);
  end

  // Apply one operation to the queue model and return the expected result
  function automatic result_t apply_queue_op(logic [2:0] kind, logic [15:0] pid,
                                             logic [3:0] st);
    result_t r;
    int      hit;
    r = '0;
    r.status = ST_OK;
    hit = -1;
    for (int i = 0; i < run_q.size(); i++) begin
      if (hit < 0 && run_q[i].pid == pid) hit = i;
    end
    case (kind)
      KIND_APPEND, KIND_PREPEND: begin
        if (hit >= 0) r.status = ST_DUP;
        else if (run_q.size() >= QUEUE_DEPTH) r.status = ST_FULL;
        else if (kind == KIND_APPEND) run_q.push_back(task_entry_t'{pid: pid, state: st});
        else run_q.push_front(task_entry_t'{pid: pid, state: st});
      end
      KIND_POP: begin
        if (run_q.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.pid = run_q[0].pid;
          r.state = run_q[0].state;
          void'(run_q.pop_front());
        end
      end
      KIND_FIND: begin
        if (hit < 0) begin
          r.status = ST_MISSING;
        end else begin
          r.pid = run_q[hit].pid;
          r.state = run_q[hit].state;
        end
      end
      KIND_CLEAR: run_q.delete();
      default: ;
    endcase
    r.count = 5'(run_q.size());
    r.is_empty = (run_q.size() == 0);
    return r;
  endfunction

  // Predict on each accepted input beat, then check each accepted result beat
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pending_results.push_back(apply_queue_op(in_tuser, in_tdata[15:0], in_tdata[19:16]));
        if (run_q.size() == QUEUE_DEPTH) full_hits++;
      end
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata[15:0], out_tdata[19:16], out_tdata[24:20], out_tdata[25]};
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: result beat with nothing expected: status %0d pid %h state %h",
                     $realtime, got.status, got.pid, got.state);
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (want.status < 5) status_hits[want.status]++;
          if (got.status !== want.status || got.pid !== want.pid ||
              got.state !== want.state || got.count !== want.count ||
              got.is_empty !== want.is_empty) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("%0t: mismatch: expected status %0d pid %h state %h count %0d empty %b",
                       $realtime, want.status, want.pid, want.state, want.count,
                       want.is_empty);
              $display("%0t:           got status %0d pid %h state %h count %0d empty %b",
                       $realtime, got.status, got.pid, got.state, got.count,
                       got.is_empty);
            end
          end
        end
      end
    end
  end

  // Send one beat, with a random gap ahead of it, and hold until taken
  task automatic send_op(input logic [2:0] kind, input logic [15:0] pid,
                         input logic [3:0] st);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0000, st, pid};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic test_empty_queue();
    send_op(KIND_POP, 16'hA5A5, 4'hA);
    send_op(KIND_FIND, 16'h0000, 4'h0);
    for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++)
      send_op(k[2:0], 16'hFFFF, 4'hF);
  endtask

  task automatic test_insert_and_duplicates();
    send_op(KIND_APPEND, 16'h0000, 4'h0);
    send_op(KIND_PREPEND, 16'hFFFF, 4'hF);
    send_op(KIND_APPEND, 16'h0000, 4'h7);
    send_op(KIND_FIND, 16'hFFFF, 4'h0);
  endtask

  task automatic test_fill_to_capacity();
    for (int i = 0; i < QUEUE_DEPTH - 2; i++)
      send_op(KIND_APPEND, 16'h0100 + 16'(i), 4'(i));
    send_op(KIND_APPEND, 16'h0200, 4'h3);
    // a queued pid must report duplicate even with the queue full
    send_op(KIND_PREPEND, 16'h0000, 4'h1);
    send_op(KIND_POP, 16'h0000, 4'h0);
    send_op(KIND_CLEAR, 16'h0000, 4'h0);
  endtask

  // Mostly a small pool of pids so that duplicates and finds hit
  function automatic logic [15:0] pick_pid();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 16'($urandom_range(23));
    if (r < 80) return 16'hFFFF - 16'($urandom_range(7));
    return 16'($urandom_range(16'hFFFF));
  endfunction

  task automatic test_random_traffic(input int n_ops, input int gap_pct, input int hold_pct);
    bit          filling;
    int          r;
    logic [2:0]  kind;
    idle_pct = gap_pct;
    stall_pct = hold_pct;
    filling = 1'b1;
    for (int i = 0; i < n_ops; i++) begin
      // swing between filling and draining so full and empty are both reached
      if (i % 40 == 0) filling = 1'($urandom_range(1));
      r = $urandom_range(99);
      if (filling) begin
        if (r < 40) kind = KIND_APPEND;
        else if (r < 70) kind = KIND_PREPEND;
        else if (r < 80) kind = KIND_POP;
        else if (r < 95) kind = KIND_FIND;
        else if (r < 96) kind = KIND_CLEAR;
        else kind = 3'($urandom_range(KIND_UNUSED_LAST, KIND_UNUSED_FIRST));
      end else begin
        if (r < 15) kind = KIND_APPEND;
        else if (r < 25) kind = KIND_PREPEND;
        else if (r < 70) kind = KIND_POP;
        else if (r < 95) kind = KIND_FIND;
        else if (r < 97) kind = KIND_CLEAR;
        else kind = 3'($urandom_range(KIND_UNUSED_LAST, KIND_UNUSED_FIRST));
      end
      send_op(kind, pick_pid(), 4'($urandom_range(15)));
    end
  endtask

  initial begin
    int drain_cycles;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queue();
    test_insert_and_duplicates();
    test_fill_to_capacity();
    test_random_traffic(170, 0, 0);
    test_random_traffic(170, 65, 0);
    test_random_traffic(170, 0, 65);
    test_random_traffic(170, 19, 19);
    in_tvalid <= 1'b0;

    drain_cycles = 0;
    while (pending_results.size() != 0 && drain_cycles < 2000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      mismatch_count += pending_results.size();
    end

    $display("Checked %0d results: ok %0d, duplicate %0d, full %0d, empty %0d, missing %0d",
             results_checked, status_hits[0], status_hits[1], status_hits[2],
             status_hits[3], status_hits[4]);
    $display("Queue held at capacity after %0d beats; %0d mismatches",
             full_hits, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out waiting for the run to finish");
    $display("FAIL");
    $finish;
  end

endmodule
